@@ rtl/ssfb_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, types and constants for the segment speed planner.
// No dependencies; every other file of the block refers to this package.
package ssfb_pkg;

    // Field widths: speeds, lengths and accelerations are unsigned Q16.8.
    localparam int SPEED_W = 24;
    // A product of two fields, and the reach term 2*a*L (Q33.16).
    localparam int PROD_W  = 2 * SPEED_W;
    localparam int TERM_W  = PROD_W + 1;
    // Radicand of the root unit: square plus reach term, Q34.16.
    localparam int RAD_W   = PROD_W + 2;
    // Root of the radicand and the partial remainder of the digit recurrence.
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 1;

    // Step counters of the serial units.
    localparam int MUL_CNT_W  = $clog2(SPEED_W);
    localparam int SQRT_CNT_W = $clog2(ROOT_W);

    // Largest speed code; roots above it saturate here.
    localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

    typedef logic [SPEED_W-1:0] t_speed;
    typedef logic [PROD_W-1:0]  t_prod;
    typedef logic [TERM_W-1:0]  t_term;
    typedef logic [RAD_W-1:0]   t_rad;
    typedef logic [ROOT_W-1:0]  t_root;

endpackage

@@ rtl/ssfb_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for segment words in and speed words out.
// Depends on ssfb_pkg for the field types.
interface ssfb_seg_if;
    logic               valid;
    logic               ready;
    ssfb_pkg::t_speed   seg_length;
    ssfb_pkg::t_speed   seg_accel;
    logic               is_last;

    modport source (output valid, output seg_length, output seg_accel, output is_last,
                    input ready);
    modport sink   (input valid, input seg_length, input seg_accel, input is_last,
                    output ready);
endinterface

interface ssfb_res_if;
    logic               valid;
    logic               ready;
    ssfb_pkg::t_speed   end_speed;
    logic               final_out;

    modport source (output valid, output end_speed, output final_out, input ready);
    modport sink   (input valid, input end_speed, input final_out, output ready);
endinterface

@@ rtl/ssfb_mul.sv @@
`timescale 1ns / 1ps
// Serial-parallel multiplier: one multiplier bit per cycle, shift and add.
// Depends on ssfb_pkg for widths and types.
module ssfb_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ssfb_pkg::t_speed  i_a,
    input  ssfb_pkg::t_speed  i_b,
    output logic              o_done,
    output ssfb_pkg::t_prod   o_prod
);

    logic                                r_busy;
    logic                                r_done;
    logic [ssfb_pkg::MUL_CNT_W-1:0]      r_cnt;
    ssfb_pkg::t_speed                    r_mcand;
    ssfb_pkg::t_speed                    r_hi;
    ssfb_pkg::t_speed                    r_lo;
    logic [ssfb_pkg::SPEED_W:0]          w_sum;

    // Add the multiplicand when the current multiplier bit is set.
    assign w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : '0);

    // Control: run for one step per multiplier bit, then pulse done.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ssfb_pkg::MUL_CNT_W'(ssfb_pkg::SPEED_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the low half holds the multiplier and fills with product bits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= i_a;
            r_hi    <= '0;
            r_lo    <= i_b;
        end else if (r_busy) begin
            r_hi <= w_sum[ssfb_pkg::SPEED_W:1];
            r_lo <= {w_sum[0], r_lo[ssfb_pkg::SPEED_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

endmodule

@@ rtl/ssfb_sqrt.sv @@
`timescale 1ns / 1ps
// Digit-recurrence square root: one root bit per cycle, truncating.
// Depends on ssfb_pkg for widths and types.
module ssfb_sqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ssfb_pkg::t_rad    i_rad,
    output logic              o_done,
    output ssfb_pkg::t_root   o_root
);

    logic                                r_busy;
    logic                                r_done;
    logic [ssfb_pkg::SQRT_CNT_W-1:0]     r_cnt;
    ssfb_pkg::t_rad                      r_rad;
    logic [ssfb_pkg::REM_W-1:0]          r_rem;
    ssfb_pkg::t_root                     r_root;
    logic [ssfb_pkg::REM_W+1:0]          w_rem2;
    logic [ssfb_pkg::REM_W+1:0]          w_trial;
    logic [ssfb_pkg::REM_W+1:0]          w_diff;
    logic                                w_ge;

    // Bring down the next two radicand bits and try root*4+1.
    assign w_rem2  = {r_rem, r_rad[ssfb_pkg::RAD_W-1 -: 2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_diff  = w_rem2 - w_trial;
    assign w_ge    = (w_rem2 >= w_trial);

    // Control: one step per root bit, then pulse done.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ssfb_pkg::SQRT_CNT_W'(ssfb_pkg::ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the remainder stays at most twice the root, so it fits REM_W bits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[ssfb_pkg::RAD_W-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[ssfb_pkg::REM_W-1:0] : w_rem2[ssfb_pkg::REM_W-1:0];
            r_root <= {r_root[ssfb_pkg::ROOT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

@@ rtl/segment_speed_forward_backward_planner_top.sv @@
`timescale 1ns / 1ps
// Segment speed planner top level: sequencer, segment stores, output register.
// Depends on ssfb_pkg, ssfb_if, ssfb_mul and ssfb_sqrt.
//
// Usage: each accepted segment word runs its forward step before the next
// one can be taken: the bit-serial multiplier forms a*L, doubled to 2*a*L, and
// the bit-serial square root takes its root. The end speed is
// min(speed_cap, sqrt(2*a*L)), which already satisfies the reach limit from
// the previous segment. On the last segment (is_last, or the segment that
// fills the MAX_SEGMENTS store) a backward pass runs once per earlier
// segment, again through the multiplier squaring the next speed and the root
// unit, then the stored speeds leave in order, each read from the store and
// loaded when the sink is ready. The output register holds the final word
// while the next segment is accepted. The stores need no clearing after reset.
module segment_speed_forward_backward_planner_top #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  ssfb_pkg::t_speed     i_cfg_wdata,
    ssfb_seg_if.sink             i_seg,
    ssfb_res_if.source           o_res
);

    localparam int ADDR_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FMUL  = 3'd1;
    localparam logic [2:0] S_FSQRT = 3'd2;
    localparam logic [2:0] S_BMUL  = 3'd3;
    localparam logic [2:0] S_BSQRT = 3'd4;
    localparam logic [2:0] S_OREAD = 3'd5;
    localparam logic [2:0] S_OLOAD = 3'd6;

    logic [2:0]              r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [ADDR_W-1:0]       r_idx, n_idx;
    logic [ADDR_W-1:0]       r_last_idx, n_last_idx;
    logic                    r_last, n_last;
    ssfb_pkg::t_speed        r_speed_cap;

    ssfb_pkg::t_speed        mem_spd [MAX_SEGMENTS];
    ssfb_pkg::t_term         mem_term [MAX_SEGMENTS];
    ssfb_pkg::t_speed        r_spd_rd;
    ssfb_pkg::t_term         r_term_rd;

    logic                    r_out_valid;
    ssfb_pkg::t_speed        r_out_speed;
    logic                    r_out_final;

    logic                    mul_start, mul_done;
    ssfb_pkg::t_speed        mul_a, mul_b;
    ssfb_pkg::t_prod         mul_prod;
    logic                    sqrt_start, sqrt_done;
    ssfb_pkg::t_rad          sqrt_rad;
    ssfb_pkg::t_root         sqrt_root;

    logic                    spd_we, term_we, out_load;
    logic [ADDR_W-1:0]       spd_waddr, w_waddr, w_rd_addr;
    ssfb_pkg::t_speed        spd_wdata;
    ssfb_pkg::t_speed        w_root_sat, w_fwd_speed, w_bwd_speed;
    ssfb_pkg::t_term         w_term;
    ssfb_pkg::t_rad          w_bwd_rad;

    // Arithmetic units shared by the forward and backward passes.
    ssfb_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    ssfb_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_rad   (sqrt_rad),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    // Saturate the root and apply the clamps of each pass.
    assign w_root_sat  = sqrt_root[ssfb_pkg::ROOT_W-1] ? ssfb_pkg::SPEED_MAX
                                                       : sqrt_root[ssfb_pkg::SPEED_W-1:0];
    assign w_fwd_speed = (w_root_sat < r_speed_cap) ? w_root_sat : r_speed_cap;
    assign w_bwd_speed = (w_root_sat < r_spd_rd) ? w_root_sat : r_spd_rd;
    assign w_term      = {mul_prod, 1'b0};
    assign w_bwd_rad   = {2'b00, mul_prod} + {1'b0, r_term_rd};

    // The backward pass reads the entry before the one it carries.
    assign w_waddr   = r_count[ADDR_W-1:0];
    assign w_rd_addr = (r_state == S_BMUL || r_state == S_BSQRT) ? r_idx - 1'b1 : r_idx;

    assign i_seg.ready = (r_state == S_IDLE);

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_cap <= ssfb_pkg::SPEED_MAX;
        end else if (i_cfg_we) begin
            r_speed_cap <= i_cfg_wdata;
        end
    end

    // Sequencer for the forward step, the backward pass and the output pass.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_last_idx = r_last_idx;
        n_last     = r_last;
        mul_start  = 1'b0;
        mul_a      = i_seg.seg_length;
        mul_b      = i_seg.seg_accel;
        sqrt_start = 1'b0;
        sqrt_rad   = {1'b0, w_term};
        spd_we     = 1'b0;
        spd_waddr  = w_waddr;
        spd_wdata  = w_fwd_speed;
        term_we    = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_seg.valid) begin
                    mul_start = 1'b1;
                    n_last    = i_seg.is_last;
                    n_state   = S_FMUL;
                end
            end
            S_FMUL: begin
                if (mul_done) begin
                    term_we    = 1'b1;
                    sqrt_start = 1'b1;
                    n_state    = S_FSQRT;
                end
            end
            S_FSQRT: begin
                if (sqrt_done) begin
                    spd_we = 1'b1;
                    if (r_last || r_count == CNT_W'(MAX_SEGMENTS - 1)) begin
                        n_count    = '0;
                        n_last_idx = w_waddr;
                        if (w_waddr == '0) begin
                            n_idx   = '0;
                            n_state = S_OREAD;
                        end else begin
                            n_idx     = w_waddr;
                            mul_start = 1'b1;
                            mul_a     = w_fwd_speed;
                            mul_b     = w_fwd_speed;
                            n_state   = S_BMUL;
                        end
                    end else begin
                        n_count = r_count + 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_BMUL: begin
                if (mul_done) begin
                    sqrt_start = 1'b1;
                    sqrt_rad   = w_bwd_rad;
                    n_state    = S_BSQRT;
                end
            end
            S_BSQRT: begin
                if (sqrt_done) begin
                    spd_we    = 1'b1;
                    spd_waddr = r_idx - 1'b1;
                    spd_wdata = w_bwd_speed;
                    n_idx     = r_idx - 1'b1;
                    if (r_idx == ADDR_W'(1)) begin
                        n_state = S_OREAD;
                    end else begin
                        mul_start = 1'b1;
                        mul_a     = w_bwd_speed;
                        mul_b     = w_bwd_speed;
                        n_state   = S_BMUL;
                    end
                end
            end
            S_OREAD: begin
                n_state = S_OLOAD;
            end
            S_OLOAD: begin
                if (!r_out_valid || o_res.ready) begin
                    out_load = 1'b1;
                    if (r_idx == r_last_idx) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_OREAD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_idx      <= '0;
            r_last_idx <= '0;
            r_last     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_idx      <= n_idx;
            r_last_idx <= n_last_idx;
            r_last     <= n_last;
        end
    end

    // Segment stores with registered read data.
    always_ff @(posedge i_clk) begin
        if (spd_we) begin
            mem_spd[spd_waddr] <= spd_wdata;
        end
        r_spd_rd <= mem_spd[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (term_we) begin
            mem_term[w_waddr] <= w_term;
        end
        r_term_rd <= mem_term[w_rd_addr];
    end

    // Output register: a word waits here while the sequencer moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_speed <= r_spd_rd;
            r_out_final <= (r_idx == r_last_idx);
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.end_speed = r_out_speed;
    assign o_res.final_out = r_out_final;

    // The two serial units never finish in the same cycle.
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_done && sqrt_done))
        else $error("multiplier and root unit finished together");

    // Loading the last word of a plan returns the sequencer to idle, marked final.
    a_final_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_idx == r_last_idx) |=>
            (r_state == S_IDLE && r_out_valid && r_out_final))
        else $error("final word did not end the output pass");

    // A segment is only accepted while the store has room for it.
    a_store_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_seg.valid && i_seg.ready) |-> (r_count <= CNT_W'(MAX_SEGMENTS - 1)))
        else $error("segment accepted into a full store");

    // An accepted segment starts the multiplier and blocks further input.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_seg.valid && i_seg.ready) |=> (r_state == S_FMUL && !i_seg.ready))
        else $error("accepted segment did not start the forward step");

endmodule
